[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/slfd_pkg.sv]
// ----------------------------------------------------------------------------
// slfd_pkg
// Types, codes and lamp decode shared by the signal lamp flash driver.
// ----------------------------------------------------------------------------
package slfd_pkg;

	localparam int NUM_HEADS = 8;
	localparam int HEAD_W = 3;
	localparam int ASPECT_W = 3;
	localparam int COUNT_W = 8;
	localparam int CFG_W = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int LAMP_W = 24;
	localparam int PAIRS = (NUM_HEADS < 8) ? NUM_HEADS : 8;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 32;

	localparam logic [COUNT_W-1:0] TPR_RESET = 8'd10;
	localparam logic [COUNT_W-1:0] RPHB_RESET = 8'd6;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_SET  = 1'b1
	} opcode_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_TICKS_PER_REFRESH    = 2'd0,
		CFG_REFRESHES_PER_HALF   = 2'd1
	} cfg_addr_t;

	typedef enum logic [ASPECT_W-1:0] {
		ASP_OFF       = 3'd0,
		ASP_GREEN     = 3'd1,
		ASP_YELLOW    = 3'd2,
		ASP_FL_YELLOW = 3'd3,
		ASP_RED       = 3'd4,
		ASP_FL_GREEN  = 3'd5,
		ASP_FL_RED    = 3'd6,
		ASP_LUNAR     = 3'd7
	} aspect_t;

	// Bit 0 is the red lamp, bit 1 the green lamp.
	function automatic logic [1:0] lamp_bits(input logic [ASPECT_W-1:0] code,
		input logic phase);
		logic [1:0] b;
		case (code)
			ASP_OFF:       b = 2'b00;
			ASP_GREEN:     b = 2'b10;
			ASP_YELLOW:    b = 2'b11;
			ASP_FL_YELLOW: b = phase ? 2'b11 : 2'b00;
			ASP_FL_GREEN:  b = phase ? 2'b10 : 2'b00;
			ASP_FL_RED:    b = phase ? 2'b01 : 2'b00;
			default:       b = 2'b01;
		endcase
		return b;
	endfunction

endpackage

[rtl/signal_lamp_flash_driver_unit.sv]
// ----------------------------------------------------------------------------
// signal_lamp_flash_driver_unit
// Lamp driver for eight three-wire searchlight signal heads.
// ----------------------------------------------------------------------------
// Each input word is either a timer tick or an aspect write for one head.
// Every ticks_per_refresh ticks the block emits one 24-bit lamp word, and
// every refreshes_per_half_blink refreshes the flash phase toggles before
// that word is built. A word is held in the input register and is then
// decoded into the output register, and a new word is taken every cycle
// while the output side keeps up.
`include "assert_macros.svh"

module signal_lamp_flash_driver_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [slfd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [slfd_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// head [2:0], aspect [5:3], zero fill [7:6]
	input  logic [slfd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode [0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// lamp_word [23:0], blink_on [24], zero fill [31:25]
	output logic [slfd_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

	logic [slfd_pkg::COUNT_W-1:0] tpr_q;
	logic [slfd_pkg::COUNT_W-1:0] rphb_q;
	logic [slfd_pkg::COUNT_W-1:0] tick_count_q;
	logic [slfd_pkg::COUNT_W-1:0] refresh_count_q;
	logic                         flash_phase_q;
	logic [slfd_pkg::ASPECT_W-1:0] aspects_q [slfd_pkg::NUM_HEADS];

	logic                          valid_s1;
	slfd_pkg::opcode_t             op_s1;
	logic [slfd_pkg::HEAD_W-1:0]   head_s1;
	logic [slfd_pkg::ASPECT_W-1:0] aspect_s1;

	logic                          out_valid_q;
	logic [slfd_pkg::LAMP_W-1:0]   out_lamp_q;
	logic                          out_blink_q;

	logic [slfd_pkg::COUNT_W:0]    tick_inc;
	logic [slfd_pkg::COUNT_W:0]    refresh_inc;
	logic                          is_tick;
	logic                          refresh_due;
	logic                          toggle_due;
	logic                          phase_next;
	logic                          out_free;
	logic                          advance_s1;
	logic                          out_load;
	logic [slfd_pkg::LAMP_W-1:0]   lamp_next;
	logic [1:0]                    pair_bits;

	assign is_tick     = (op_s1 == slfd_pkg::OP_TICK);
	assign tick_inc    = {1'b0, tick_count_q} + 9'd1;
	assign refresh_inc = {1'b0, refresh_count_q} + 9'd1;
	assign refresh_due = is_tick && (tick_inc >= {1'b0, tpr_q});
	assign toggle_due  = refresh_inc >= {1'b0, rphb_q};
	assign phase_next  = flash_phase_q ^ toggle_due;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance_s1    = valid_s1 && (!refresh_due || out_free);
	assign out_load      = advance_s1 && refresh_due;
	assign s_axis_tready = !valid_s1 || advance_s1;

	always_comb begin
		lamp_next = '0;
		pair_bits = '0;
		for (int i = 0; i < slfd_pkg::PAIRS; i++) begin
			pair_bits = slfd_pkg::lamp_bits(
				aspects_q[(i + slfd_pkg::NUM_HEADS / 2) % slfd_pkg::NUM_HEADS],
				phase_next);
			lamp_next[3*i]     = pair_bits[0];
			lamp_next[3*i + 2] = pair_bits[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q  <= slfd_pkg::TPR_RESET;
			rphb_q <= slfd_pkg::RPHB_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				slfd_pkg::CFG_TICKS_PER_REFRESH:  tpr_q  <= cfg_data;
				slfd_pkg::CFG_REFRESHES_PER_HALF: rphb_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1     <= slfd_pkg::opcode_t'(s_axis_tuser);
			head_s1   <= s_axis_tdata[slfd_pkg::HEAD_W-1:0];
			aspect_s1 <= s_axis_tdata[slfd_pkg::HEAD_W +: slfd_pkg::ASPECT_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q    <= '0;
			refresh_count_q <= '0;
			flash_phase_q   <= 1'b0;
			for (int j = 0; j < slfd_pkg::NUM_HEADS; j++) begin
				aspects_q[j] <= slfd_pkg::ASP_RED;
			end
		end else if (advance_s1) begin
			if (!is_tick) begin
				aspects_q[head_s1] <= aspect_s1;
			end else if (!refresh_due) begin
				tick_count_q <= tick_inc[slfd_pkg::COUNT_W-1:0];
			end else begin
				tick_count_q  <= '0;
				flash_phase_q <= phase_next;
				refresh_count_q <= toggle_due ? '0 : refresh_inc[slfd_pkg::COUNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_lamp_q  <= lamp_next;
			out_blink_q <= phase_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_blink_q, out_lamp_q};

	`ASSERT_NEXT(a_load_shows, out_load, out_valid_q)
	`ASSERT_NEXT(a_blink_matches_phase, out_load, out_blink_q == flash_phase_q)
	`ASSERT_NEXT(a_refresh_count_holds, !out_load, $stable(refresh_count_q))
	`ASSERT_IMPL(a_mid_bits_zero, out_valid_q, (out_lamp_q & 24'h492492) == 24'd0)

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the signal lamp flash driver.
// ----------------------------------------------------------------------------
// Aspect writes and timer ticks go in on the input stream. A scoreboard
// predicts every lamp word from its own copy of the aspects, counters and
// registers, and checks each word that leaves the block. The register
// settings change between phases, and each phase uses one of four
// patterns of sender gaps and receiver stalls.
`timescale 1ns / 1ps

typedef struct packed {
	logic [slfd_pkg::LAMP_W-1:0] lamp;
	logic                        blink;
} lamp_out_t;

class lamp_scoreboard;
	slfd_pkg::aspect_t                aspects[slfd_pkg::NUM_HEADS];
	logic [slfd_pkg::COUNT_W-1:0]     tick_cnt;
	logic [slfd_pkg::COUNT_W-1:0]     refresh_cnt;
	logic                             phase;
	logic [slfd_pkg::CFG_W-1:0]       ticks_per_refresh;
	logic [slfd_pkg::CFG_W-1:0]       refreshes_per_half;
	lamp_out_t                        expected_lamps[$];
	int                               mismatches;

	function new();
		for (int h = 0; h < slfd_pkg::NUM_HEADS; h++)
			aspects[h] = slfd_pkg::ASP_RED;
		tick_cnt = '0;
		refresh_cnt = '0;
		phase = 1'b0;
		ticks_per_refresh = slfd_pkg::TPR_RESET;
		refreshes_per_half = slfd_pkg::RPHB_RESET;
		mismatches = 0;
	endfunction

	function void write_reg(logic [slfd_pkg::CFG_ADDR_W-1:0] addr,
		logic [slfd_pkg::CFG_W-1:0] data);
		if (addr == slfd_pkg::CFG_TICKS_PER_REFRESH)
			ticks_per_refresh = data;
		else if (addr == slfd_pkg::CFG_REFRESHES_PER_HALF)
			refreshes_per_half = data;
	endfunction

	function logic [1:0] decode(slfd_pkg::aspect_t code);
		case (code)
			slfd_pkg::ASP_OFF:       return 2'b00;
			slfd_pkg::ASP_GREEN:     return 2'b10;
			slfd_pkg::ASP_YELLOW:    return 2'b11;
			slfd_pkg::ASP_FL_YELLOW: return phase ? 2'b11 : 2'b00;
			slfd_pkg::ASP_FL_GREEN:  return phase ? 2'b10 : 2'b00;
			slfd_pkg::ASP_FL_RED:    return phase ? 2'b01 : 2'b00;
			default:                 return 2'b01;
		endcase
	endfunction

	function void take_word(slfd_pkg::opcode_t op, logic [slfd_pkg::HEAD_W-1:0] head,
		slfd_pkg::aspect_t aspect);
		logic [slfd_pkg::COUNT_W:0] next;
		lamp_out_t                  out;
		logic [1:0]                 b;
		if (op == slfd_pkg::OP_SET) begin
			aspects[head] = aspect;
			return;
		end
		next = {1'b0, tick_cnt} + 9'd1;
		if (next < {1'b0, ticks_per_refresh}) begin
			tick_cnt = next[slfd_pkg::COUNT_W-1:0];
			return;
		end
		tick_cnt = '0;
		next = {1'b0, refresh_cnt} + 9'd1;
		if (next >= {1'b0, refreshes_per_half}) begin
			phase = ~phase;
			refresh_cnt = '0;
		end else begin
			refresh_cnt = next[slfd_pkg::COUNT_W-1:0];
		end
		out.lamp = '0;
		for (int i = 0; i < slfd_pkg::PAIRS; i++) begin
			b = decode(aspects[(i + slfd_pkg::NUM_HEADS / 2) % slfd_pkg::NUM_HEADS]);
			out.lamp[3 * i] = b[0];
			out.lamp[3 * i + 2] = b[1];
		end
		out.blink = phase;
		expected_lamps.push_back(out);
	endfunction

	function void check_lamp(logic [slfd_pkg::LAMP_W-1:0] lamp, logic blink);
		lamp_out_t exp_out;
		if (expected_lamps.size() == 0) begin
			if (mismatches < 10)
				$display("Unexpected word: lamp %06h blink %0b", lamp, blink);
			mismatches++;
			return;
		end
		exp_out = expected_lamps.pop_front();
		if (lamp !== exp_out.lamp || blink !== exp_out.blink) begin
			if (mismatches < 10)
				$display("Wrong word: lamp %06h blink %0b, expected lamp %06h blink %0b",
					lamp, blink, exp_out.lamp, exp_out.blink);
			mismatches++;
		end
	endfunction

	function int pending();
		return expected_lamps.size();
	endfunction
endclass

module tb_top;

	localparam logic [slfd_pkg::CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [slfd_pkg::CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam int DRAIN_CYCLES = 6;
	localparam int DRAIN_LIMIT = 5000;
	localparam int NUM_PHASES = 8;

	logic                               clk;
	logic                               arst_n;
	logic                               cfg_we;
	logic [slfd_pkg::CFG_ADDR_W-1:0]    cfg_addr;
	logic [slfd_pkg::CFG_W-1:0]         cfg_data;
	logic                               s_axis_tvalid;
	logic                               s_axis_tready;
	logic [slfd_pkg::IN_DATA_W-1:0]     s_axis_tdata;
	logic                               s_axis_tuser;
	logic                               m_axis_tvalid;
	logic                               m_axis_tready;
	logic [slfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata;

	lamp_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;

	signal_lamp_flash_driver_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_lamp(m_axis_tdata[slfd_pkg::LAMP_W-1:0], m_axis_tdata[slfd_pkg::LAMP_W]);
	end

	task automatic write_reg(input logic [slfd_pkg::CFG_ADDR_W-1:0] addr,
		input logic [slfd_pkg::CFG_W-1:0] data);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(addr, data);
	endtask

	task automatic send_word(input slfd_pkg::opcode_t op,
		input logic [slfd_pkg::HEAD_W-1:0] head, input slfd_pkg::aspect_t aspect);
		int gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = op;
		s_axis_tdata = {2'b00, aspect, head};
		do @(posedge clk); while (!s_axis_tready);
		sb.take_word(op, head, aspect);
		@(negedge clk);
	endtask

	task automatic drain_lamps();
		int n = 0;
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		#5000000;
		$display("signal_lamp_flash_driver_unit: mismatch");
		$finish;
	end

	initial begin
		int tpr_set[NUM_PHASES]   = '{8'd1, 8'd3, 8'd0, 8'd255, 8'd2, 8'd1, 8'd1, 8'd1};
		int rphb_set[NUM_PHASES]  = '{8'd1, 8'd2, 8'd3, 8'd255, 8'd1, 8'd200, 8'd5, 8'd2};
		int mode_set[NUM_PHASES]  = '{0, 1, 2, 3, 0, 1, 2, 0};
		int count_set[NUM_PHASES] = '{200, 200, 200, 150, 120, 150, 150, 180};
		int tick_set[NUM_PHASES]  = '{60, 70, 60, 90, 60, 70, 70, 80};
		slfd_pkg::opcode_t op;
		int rnd_head;
		int rnd_aspect;
		int rnd_spare;

		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = slfd_pkg::CFG_TICKS_PER_REFRESH;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tuser = slfd_pkg::OP_TICK;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Every aspect on its own head, then one refresh with the phase off.
		for (int h = 0; h < slfd_pkg::NUM_HEADS; h++)
			send_word(slfd_pkg::OP_SET, h[slfd_pkg::HEAD_W-1:0], slfd_pkg::aspect_t'(h));
		repeat (10) send_word(slfd_pkg::OP_TICK, '0, slfd_pkg::ASP_OFF);
		drain_lamps();

		// Zero in both registers: every tick refreshes and toggles the phase.
		write_reg(slfd_pkg::CFG_TICKS_PER_REFRESH, 8'd0);
		write_reg(slfd_pkg::CFG_REFRESHES_PER_HALF, 8'd0);
		repeat (3) send_word(slfd_pkg::OP_TICK, 3'd7, slfd_pkg::ASP_LUNAR);
		drain_lamps();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(slfd_pkg::CFG_TICKS_PER_REFRESH, tpr_set[p][slfd_pkg::CFG_W-1:0]);
			write_reg(slfd_pkg::CFG_REFRESHES_PER_HALF, rphb_set[p][slfd_pkg::CFG_W-1:0]);
			rnd_spare = $urandom_range(255);
			write_reg(CFG_SPARE_2, rnd_spare[slfd_pkg::CFG_W-1:0]);
			rnd_spare = $urandom_range(255);
			write_reg(CFG_SPARE_3, rnd_spare[slfd_pkg::CFG_W-1:0]);
			send_idle_pct = (mode_set[p] == 1) ? 69 : (mode_set[p] == 3) ? 16 : 0;
			recv_stall_pct = (mode_set[p] == 2) ? 69 : (mode_set[p] == 3) ? 16 : 0;
			if (p == NUM_PHASES - 1)
				hold_left = 300;
			for (int k = 0; k < count_set[p]; k++) begin
				op = ($urandom_range(99) < tick_set[p]) ? slfd_pkg::OP_TICK : slfd_pkg::OP_SET;
				rnd_head = $urandom_range(7);
				rnd_aspect = $urandom_range(7);
				send_word(op, rnd_head[slfd_pkg::HEAD_W-1:0],
					slfd_pkg::aspect_t'(rnd_aspect[slfd_pkg::ASPECT_W-1:0]));
			end
			drain_lamps();
		end

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("signal_lamp_flash_driver_unit: match");
		else
			$display("signal_lamp_flash_driver_unit: mismatch");
		$finish;
	end

endmodule
